FILE: hdl/qcp_pkg.sv
// qcp_pkg: shared types, constants and the quarter-wave sine entry function
// for the quadraphonic circle panner and mixer. No dependencies.
package qcp_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int MIX_W    = 32;
    localparam int SINE_W   = 15;
    localparam int CFG_IDX_W = 2;

    // Shared serial multiplier: 16-bit multiplicand, 18-bit multiplier
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    // Phase offset of 0.625 turn and pi/2 in Q30
    localparam logic [15:0] PHASE_OFFSET = 16'hA000;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd1;

    // Reset values of the registers
    localparam logic [COEF_W-1:0] AMPLITUDE_RST = 16'h4000;
    localparam logic [COEF_W-1:0] OFFSET_RST    = 16'h0000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_S,
        ST_RD_C,
        ST_CAP_C,
        ST_GAIN_GO,
        ST_GAIN_RUN,
        ST_PROD_RUN,
        ST_EMIT
    } t_state;

    // Start request to the serial multiplier
    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } t_mul_req;

    // Four saturated mixes: rear left, rear right, front right, front left
    typedef logic [3:0][MIX_W-1:0] t_mix;

    // Quarter-wave sine entry k of a table with 2^qb steps per quadrant.
    // Ten-term Taylor series in Q30, each term truncated, rounded to Q15.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                       input int unsigned qb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (longint'(k) * PI_HALF_Q30) >> qb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;    sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;   sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;   sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 272;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 342;  sum = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 32767) begin
            sum = 32767;
        end
        return SINE_W'(sum);
    endfunction

endpackage

FILE: hdl/quad_circle_pan_mixer.sv
// quad_circle_pan_mixer: top level, sequencer, sine addressing, gain forming.
// Depends on qcp_pkg, qcp_sine_rom, qcp_serial_mult, qcp_acc_bank.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------------
//  input    | i_in_valid / o_in_ready   | i_sample, i_position, i_last_channel
//  output   | o_out_valid / i_out_ready | o_rear_left, o_rear_right,
//           |                           | o_front_right, o_front_left
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// Each item runs from one acceptance to the next as: the accepting cycle, the
// sine look-up of s and c, then per speaker a start, a gain multiply and a product
// multiply on the one bit-serial multiplier; a last item adds a step to move the
// mixes to the output register. Input is ready only while no item is in work.
// Reset is synchronous, active low; it restores the registers and clears the mixes.
// A result waiting at the output does not block input; only a last item stalls
// in its final cycle until the output register is free.
module quad_circle_pan_mixer #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int ACC_WIDTH      = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [15:0]      i_sample,
    input  logic [15:0]             i_position,
    input  logic                    i_last_channel,
    // results
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [31:0]      o_rear_left,
    output logic signed [31:0]      o_rear_right,
    output logic signed [31:0]      o_front_right,
    output logic signed [31:0]      o_front_left,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);

    localparam int QB = SINE_ADDR_BITS - 2;
    localparam logic [QB:0] QTR = {1'b1, {QB{1'b0}}};
    localparam logic [1:0]  LANE_LAST = 2'd3;
    localparam logic signed [qcp_pkg::MUL_B_W-1:0] HALF_Q16 = 18'sd32768;

    qcp_pkg::t_state r_state, n_state;

    logic signed [15:0]      r_amplitude;
    logic signed [15:0]      r_offset;
    logic signed [15:0]      r_sample;
    logic [1:0]              r_quad;
    logic [QB-1:0]           r_k;
    logic                    r_last;
    logic [1:0]              r_lane;
    logic signed [15:0]      r_s;
    logic signed [15:0]      r_c;
    logic                    r_out_valid;
    qcp_pkg::t_mix           r_out_mix;

    logic [15:0]             w_phase;
    logic [SINE_ADDR_BITS-1:0] w_idx;
    logic [QB:0]             w_addr_s;
    logic [QB:0]             w_addr_c;
    logic [QB:0]             w_rom_addr;
    logic [qcp_pkg::SINE_W-1:0] w_rom_data;
    logic signed [15:0]      w_rom_pos;
    logic signed [15:0]      w_sel;
    logic signed [qcp_pkg::MUL_B_W-1:0] w_weight;
    logic signed [18:0]      w_gain_sum;
    logic signed [15:0]      w_gain;
    qcp_pkg::t_mul_req       w_mul_req;
    logic                    w_mul_done;
    logic signed [qcp_pkg::MUL_P_W-1:0] w_mul_prod;
    logic                    w_in_take;
    logic                    w_acc_add;
    logic                    w_emit;
    qcp_pkg::t_mix           w_mix;

    // Phase and table addresses; c sits one quadrant on from s
    assign w_phase  = i_position + qcp_pkg::PHASE_OFFSET;
    assign w_idx    = w_phase[15 -: SINE_ADDR_BITS];
    assign w_addr_s = r_quad[0] ? (QTR - {1'b0, r_k}) : {1'b0, r_k};
    assign w_addr_c = r_quad[0] ? {1'b0, r_k} : (QTR - {1'b0, r_k});
    assign w_rom_pos = {1'b0, w_rom_data};

    // Weight for the current lane: 0.5 +- 0.5*s or 0.5 +- 0.5*c in Q16
    assign w_sel    = r_lane[0] ? r_c : r_s;
    assign w_weight = r_lane[1] ? HALF_Q16 - qcp_pkg::MUL_B_W'(w_sel)
                                : HALF_Q16 + qcp_pkg::MUL_B_W'(w_sel);

    // Gain = offset + floor(amplitude*w / 2^16), saturated to Q2.14
    always_comb begin
        w_gain_sum = 19'(r_offset)
                   + 19'($signed(w_mul_prod[qcp_pkg::MUL_P_W-1:16]));
        if (w_gain_sum > 19'sd32767) begin
            w_gain = 16'sh7FFF;
        end else if (w_gain_sum < -19'sd32768) begin
            w_gain = -16'sh8000;
        end else begin
            w_gain = w_gain_sum[15:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qcp_pkg::ST_IDLE:     if (i_in_valid) n_state = qcp_pkg::ST_RD_S;
            qcp_pkg::ST_RD_S:     n_state = qcp_pkg::ST_RD_C;
            qcp_pkg::ST_RD_C:     n_state = qcp_pkg::ST_CAP_C;
            qcp_pkg::ST_CAP_C:    n_state = qcp_pkg::ST_GAIN_GO;
            qcp_pkg::ST_GAIN_GO:  n_state = qcp_pkg::ST_GAIN_RUN;
            qcp_pkg::ST_GAIN_RUN: if (w_mul_done) n_state = qcp_pkg::ST_PROD_RUN;
            qcp_pkg::ST_PROD_RUN: begin
                if (w_mul_done) begin
                    if (r_lane != LANE_LAST) begin
                        n_state = qcp_pkg::ST_GAIN_GO;
                    end else if (r_last) begin
                        n_state = qcp_pkg::ST_EMIT;
                    end else begin
                        n_state = qcp_pkg::ST_IDLE;
                    end
                end
            end
            qcp_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) n_state = qcp_pkg::ST_IDLE;
            end
            default:              n_state = qcp_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready      = 1'b0;
        w_rom_addr      = w_addr_s;
        w_mul_req.start = 1'b0;
        w_mul_req.a     = r_amplitude;
        w_mul_req.b     = w_weight;
        w_acc_add       = 1'b0;
        w_emit          = 1'b0;
        unique case (r_state)
            qcp_pkg::ST_IDLE:     o_in_ready = 1'b1;
            qcp_pkg::ST_RD_S:     w_rom_addr = w_addr_s;
            qcp_pkg::ST_RD_C:     w_rom_addr = w_addr_c;
            qcp_pkg::ST_CAP_C:    w_rom_addr = w_addr_c;
            qcp_pkg::ST_GAIN_GO:  w_mul_req.start = 1'b1;
            qcp_pkg::ST_GAIN_RUN: begin
                w_mul_req.start = w_mul_done;
                w_mul_req.a     = r_sample;
                w_mul_req.b     = qcp_pkg::MUL_B_W'(w_gain);
            end
            qcp_pkg::ST_PROD_RUN: w_acc_add = w_mul_done;
            qcp_pkg::ST_EMIT:     w_emit = !r_out_valid || i_out_ready;
            default:              o_in_ready = 1'b0;
        endcase
    end

    assign w_in_take = i_in_valid && o_in_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qcp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_lane      <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_take) begin
                r_lane <= '0;
            end else if (w_acc_add) begin
                r_lane <= r_lane + 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= qcp_pkg::AMPLITUDE_RST;
            r_offset    <= qcp_pkg::OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qcp_pkg::REG_AMPLITUDE: r_amplitude <= i_cfg_data;
                qcp_pkg::REG_OFFSET:    r_offset    <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    // Item payload, sine values and result register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_sample <= i_sample;
            r_quad   <= w_idx[SINE_ADDR_BITS-1 -: 2];
            r_k      <= w_idx[QB-1:0];
            r_last   <= i_last_channel;
        end
        if (r_state == qcp_pkg::ST_RD_C) begin
            r_s <= r_quad[1] ? -w_rom_pos : w_rom_pos;
        end
        if (r_state == qcp_pkg::ST_CAP_C) begin
            r_c <= (r_quad[1] ^ r_quad[0]) ? -w_rom_pos : w_rom_pos;
        end
        if (w_emit) begin
            r_out_mix <= w_mix;
        end
    end

    qcp_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    qcp_serial_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    qcp_acc_bank #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (w_acc_add),
        .i_lane  (r_lane),
        .i_prod  (w_mul_prod[qcp_pkg::MIX_W-1:0]),
        .i_clear (w_emit),
        .o_mix   (w_mix)
    );

    assign o_out_valid   = r_out_valid;
    assign o_rear_left   = r_out_mix[0];
    assign o_rear_right  = r_out_mix[1];
    assign o_front_right = r_out_mix[2];
    assign o_front_left  = r_out_mix[3];

    // A result appears only after the mixes were moved out
    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == qcp_pkg::ST_EMIT))
        else $error("result valid without emit");

    // Mixes read zero after they were moved to the output
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (w_mix == '0))
        else $error("accumulators not cleared after emit");

    // The multiplier finishes only while the sequencer waits on it
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == qcp_pkg::ST_GAIN_RUN
                        || r_state == qcp_pkg::ST_PROD_RUN))
        else $error("multiplier done in unexpected state");

endmodule

FILE: hdl/qcp_sine_rom.sv
// qcp_sine_rom: quarter-wave sine table, built at elaboration, registered read.
// Depends on qcp_pkg (quarter_sine, SINE_W).
module qcp_sine_rom #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                            i_clk,
    input  logic [SINE_ADDR_BITS-2:0]       i_addr,
    output logic [qcp_pkg::SINE_W-1:0]      o_data
);

    localparam int QB    = SINE_ADDR_BITS - 2;
    localparam int DEPTH = (1 << QB) + 1;

    logic [qcp_pkg::SINE_W-1:0] w_rom [0:DEPTH-1];
    logic [qcp_pkg::SINE_W-1:0] r_data;

    // Constant entries 0 .. quarter turn inclusive
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign w_rom[k] = qcp_pkg::quarter_sine(k, QB);
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: hdl/qcp_serial_mult.sv
// qcp_serial_mult: signed shift-add multiplier, one multiplier bit per cycle.
// Depends on qcp_pkg (t_mul_req, MUL_* widths).
module qcp_serial_mult (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qcp_pkg::t_mul_req               i_req,
    output logic                            o_done,
    output logic signed [qcp_pkg::MUL_P_W-1:0] o_prod
);

    localparam int AW = qcp_pkg::MUL_A_W;
    localparam int BW = qcp_pkg::MUL_B_W;
    localparam logic [qcp_pkg::MUL_CNT_W-1:0] LAST_STEP = qcp_pkg::MUL_CNT_W'(BW - 1);

    logic signed [AW-1:0]            r_a;
    logic signed [AW:0]              r_hi;
    logic [BW-1:0]                   r_lo;
    logic [qcp_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic                            r_busy;
    logic                            r_done;

    logic signed [AW:0]              w_addend;
    logic signed [AW:0]              w_sum;

    // Partial product step; the sign bit of the multiplier subtracts
    always_comb begin
        if (!r_lo[0]) begin
            w_addend = '0;
        end else if (r_cnt == LAST_STEP) begin
            w_addend = -{r_a[AW-1], r_a};
        end else begin
            w_addend = {r_a[AW-1], r_a};
        end
        w_sum = r_hi + w_addend;
    end

    // Control: busy for one step per multiplier bit after a start, then a done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath: product shifts right through {hi, lo}
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_hi <= {w_sum[AW], w_sum[AW:1]};
            r_lo <= {w_sum[0], r_lo[BW-1:1]};
        end else if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[AW-1:0], r_lo};

endmodule

FILE: hdl/qcp_acc_bank.sv
// qcp_acc_bank: four saturating mix accumulators with 32-bit saturated view.
// Depends on qcp_pkg (t_mix, MIX_W).
module qcp_acc_bank #(
    parameter int ACC_WIDTH = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_add,
    input  logic [1:0]                          i_lane,
    input  logic signed [qcp_pkg::MIX_W-1:0]    i_prod,
    input  logic                                i_clear,
    output qcp_pkg::t_mix                       o_mix
);

    localparam int MW = qcp_pkg::MIX_W;

    logic signed [ACC_WIDTH-1:0] r_acc [0:3];
    logic signed [ACC_WIDTH:0]   w_sum;
    logic signed [ACC_WIDTH-1:0] w_sat;

    // Saturating add of the product into the selected lane
    always_comb begin
        w_sum = {r_acc[i_lane][ACC_WIDTH-1], r_acc[i_lane]}
              + (ACC_WIDTH+1)'(i_prod);
        if (w_sum[ACC_WIDTH] != w_sum[ACC_WIDTH-1]) begin
            w_sat = w_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_add) begin
            r_acc[i_lane] <= w_sat;
        end
    end

    // Saturate each lane to 32 bits for the output
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_acc[i][ACC_WIDTH-1:MW-1] == '0
                || r_acc[i][ACC_WIDTH-1:MW-1] == '1) begin
                o_mix[i] = r_acc[i][MW-1:0];
            end else if (r_acc[i][ACC_WIDTH-1]) begin
                o_mix[i] = {1'b1, {(MW-1){1'b0}}};
            end else begin
                o_mix[i] = {1'b0, {(MW-1){1'b1}}};
            end
        end
    end

endmodule
